/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/pse_pkg.sv */
// Types and constants for the postfix stack evaluator.
`default_nettype none

package pse_pkg;

    localparam int DATA_W = 32;
    localparam int ITER_W = $clog2(DATA_W);
    localparam int ADD_W  = DATA_W + 2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_R,
        S_POP_L,
        S_EXEC,
        S_NEG_A,
        S_NEG_B,
        S_DIV,
        S_NEG_Q,
        S_MUL,
        S_PUSH,
        S_FIN
    } state_t;

endpackage

`default_nettype wire

/* rtl/postfix_stack_evaluator.sv */
// Postfix expression evaluator: operand stack in RAM, one shared adder under a sequencer.
//
// Input channel s_*: one ASCII character per transfer in s_tdata; s_tuser high marks
// a finish item, which pops the top of stack and emits it. Digits push 0 to 9;
// + - * / pop right then left operand and push the 32-bit wrapping result. Other
// characters are dropped. Popping an empty stack yields -1.
// Output channel m_*: one transfer per finish item; m_tdata holds the value, m_tuser
// bit 0 a dropped push (stack full), bit 1 a division by zero, both since the last finish.
// s_tready is low after each accepted item until its sequence ends: a digit or ignored
// character needs only its transfer; add and subtract pop both operands, add and push;
// multiply makes 32 shift-add passes through the adder; divide makes two magnitude negations,
// 32 restoring steps and one sign fix, all through the adder (a zero divisor skips to the push).
// The output register frees the sequencer: a finish waits only while an earlier result
// is still held. A stalled receiver holds m_tvalid and m_tdata steady.
// Reset (aresetn low, synchronous) empties the stack, clears both flags and drops any
// held result; stack RAM contents are not cleared.
`default_nettype none

module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] value
    output logic [1:0]       m_tuser    // [0] overflowed, [1] div_zero
);

    import pse_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               dz_reg, dz_next;
    logic [DATA_W-1:0]  a_reg, a_next;
    logic [DATA_W-1:0]  b_reg, b_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic               sign_reg, sign_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [1:0]         m_tuser_reg, m_tuser_next;

    logic [ADD_W-1:0]   add_x, add_y, add_sum;
    logic               add_cin;

    logic               wr_en;
    logic [DATA_W-1:0]  wr_data;
    logic [DATA_W-1:0]  rd_data;
    logic [CW-1:0]      count_m1;
    logic [DATA_W-1:0]  pop_value;
    logic               accept, is_digit, is_op, out_free, last_iter;
    op_t                op_dec;

    assign accept    = s_tvalid && s_tready;
    assign is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign pop_value = (count_reg != '0) ? rd_data : EMPTY_VALUE;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_iter = (iter_reg == '1);
    assign count_m1  = count_next - COUNT_ONE;
    assign add_sum   = add_x + add_y + ADD_W'(add_cin);

    always_comb begin
        is_op  = 1'b1;
        op_dec = OP_ADD;
        unique case (s_tdata)
            CH_PLUS:  op_dec = OP_ADD;
            CH_MINUS: op_dec = OP_SUB;
            CH_STAR:  op_dec = OP_MUL;
            CH_SLASH: op_dec = OP_DIV;
            default:  is_op  = 1'b0;
        endcase
    end

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (count_m1[AW-1:0]),
        .rd_data (rd_data)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser) begin
                        state_next = S_FIN;
                    end else if (!is_digit && is_op) begin
                        state_next = S_POP_R;
                    end
                end
            end
            S_POP_R: state_next = S_POP_L;
            S_POP_L: begin
                unique case (op_reg)
                    OP_ADD, OP_SUB: state_next = S_EXEC;
                    OP_MUL:         state_next = S_MUL;
                    OP_DIV:         state_next = (b_reg == '0) ? S_PUSH : S_NEG_A;
                    default:        state_next = S_EXEC;
                endcase
            end
            S_EXEC:  state_next = S_PUSH;
            S_NEG_A: state_next = S_NEG_B;
            S_NEG_B: state_next = S_DIV;
            S_DIV:   state_next = last_iter ? S_NEG_Q : S_DIV;
            S_NEG_Q: state_next = S_PUSH;
            S_MUL:   state_next = last_iter ? S_PUSH : S_MUL;
            S_PUSH:  state_next = S_IDLE;
            S_FIN:   state_next = out_free ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        s_tready      = 1'b0;
        op_next       = op_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        dz_next       = dz_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        acc_next      = acc_reg;
        sign_next     = sign_reg;
        iter_next     = iter_reg;
        wr_en         = 1'b0;
        wr_data       = acc_reg;
        add_x         = '0;
        add_y         = '0;
        add_cin       = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    op_next = op_dec;
                    if (!s_tuser && is_digit) begin
                        wr_data = DATA_W'(s_tdata[3:0] - CH_ZERO[3:0]);
                        if (count_reg < COUNT_FULL) begin
                            wr_en      = 1'b1;
                            count_next = count_reg + COUNT_ONE;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end
            S_POP_R: begin
                b_next = pop_value;
                if (count_reg != '0) begin
                    count_next = count_reg - COUNT_ONE;
                end
            end
            S_POP_L: begin
                a_next = pop_value;
                if (count_reg != '0) begin
                    count_next = count_reg - COUNT_ONE;
                end
                acc_next  = '0;
                iter_next = '0;
                if (op_reg == OP_DIV && b_reg == '0) begin
                    dz_next = 1'b1;
                end
            end
            S_EXEC: begin
                add_x = {2'b00, a_reg};
                if (op_reg == OP_SUB) begin
                    add_y   = ~{2'b00, b_reg};
                    add_cin = 1'b1;
                end else begin
                    add_y = {2'b00, b_reg};
                end
                acc_next = add_sum[DATA_W-1:0];
            end
            S_NEG_A: begin
                add_y     = {2'b00, ~a_reg};
                add_cin   = 1'b1;
                sign_next = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
                if (a_reg[DATA_W-1]) begin
                    a_next = add_sum[DATA_W-1:0];
                end
            end
            S_NEG_B: begin
                add_y   = {2'b00, ~b_reg};
                add_cin = 1'b1;
                if (b_reg[DATA_W-1]) begin
                    b_next = add_sum[DATA_W-1:0];
                end
            end
            S_DIV: begin
                add_x     = {1'b0, acc_reg, a_reg[DATA_W-1]};
                add_y     = ~{2'b00, b_reg};
                add_cin   = 1'b1;
                iter_next = iter_reg + ITER_W'(1);
                if (!add_sum[ADD_W-1]) begin
                    acc_next = add_sum[DATA_W-1:0];
                    a_next   = {a_reg[DATA_W-2:0], 1'b1};
                end else begin
                    acc_next = {acc_reg[DATA_W-2:0], a_reg[DATA_W-1]};
                    a_next   = {a_reg[DATA_W-2:0], 1'b0};
                end
            end
            S_NEG_Q: begin
                add_y    = {2'b00, ~a_reg};
                add_cin  = 1'b1;
                acc_next = sign_reg ? add_sum[DATA_W-1:0] : a_reg;
            end
            S_MUL: begin
                add_x     = {2'b00, acc_reg};
                add_y     = b_reg[0] ? {2'b00, a_reg} : '0;
                acc_next  = add_sum[DATA_W-1:0];
                a_next    = {a_reg[DATA_W-2:0], 1'b0};
                b_next    = {1'b0, b_reg[DATA_W-1:1]};
                iter_next = iter_reg + ITER_W'(1);
            end
            S_PUSH: begin
                if (count_reg < COUNT_FULL) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + COUNT_ONE;
                end else begin
                    ovf_next = 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pop_value;
                    m_tuser_next  = {dz_reg, ovf_reg};
                    count_next    = '0;
                    ovf_next      = 1'b0;
                    dz_next       = 1'b0;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            dz_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            dz_reg       <= dz_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        acc_reg     <= acc_next;
        sign_reg    <= sign_next;
        iter_reg    <= iter_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

/* rtl/pse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/pse_checker.sv */
// Port-level checker for the postfix stack evaluator, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module pse_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    import pse_pkg::*;

    logic s_xfer, digit_xfer;

    assign s_xfer     = s_tvalid && s_tready;
    assign digit_xfer = s_xfer && !s_tuser && (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);

    `ASSERT_NEXT_ALWAYS(a_reset_drops_result, aclk, !aresetn, !m_tvalid)
    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `ASSERT_NEXT(a_finish_busy, aclk, aresetn, s_xfer && s_tuser, !s_tready)
    `ASSERT_NEXT(a_digit_one_cycle, aclk, aresetn, digit_xfer, s_tready)

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/postfix_stack_evaluator_tb.sv */
// Self-checking testbench for the postfix stack evaluator: directed table, then random expressions.
`timescale 1ns / 1ps

module postfix_stack_evaluator_tb;
    import pse_pkg::*;

    localparam int EVAL_DEPTH  = 128;
    localparam int QUIET_LIMIT = 2000;
    localparam int RAND_ITEMS  = 900;
    localparam int DIR_ROWS    = 11;

    typedef struct packed {
        logic [31:0] value;
        logic        ovf;
        logic        dz;
    } expr_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [31:0] m_tdata;
    wire logic [1:0]  m_tuser;

    logic [31:0]  eval_stack [EVAL_DEPTH];
    int           eval_depth = 0;
    logic         eval_ovf   = 1'b0;
    logic         eval_dz    = 1'b0;
    expr_result_t awaited_results [$];

    int fail_count     = 0;
    int quiet_cycles   = 0;
    int live_items     = 0;
    int src_idle_pct   = 20;
    int sink_stall_pct = 67;

    // Directed table: optional NUL characters, the characters of a row, repeated, then a finish transfer.
    string       dir_text [DIR_ROWS] = '{"", "90/", "+", "7", "88*8*8*8*8*8*8*8*8*2*01-/",
                                         "95-34*+", "09-2/", "5 a\n:,.)\377", "12", "9-", ""};
    int          dir_reps [DIR_ROWS] = '{1, 1, 1, 129, 1, 1, 1, 1, 1, 1, 1};
    int          dir_nul  [DIR_ROWS] = '{0, 0, 0, 0, 0, 0, 0, 2, 0, 0, 0};
    bit          dir_chk  [DIR_ROWS] = '{1, 1, 1, 1, 1, 0, 0, 1, 0, 0, 0};
    logic [31:0] dir_val  [DIR_ROWS] = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFE, 32'd7,
                                         32'h8000_0000, 32'h0, 32'h0, 32'd5, 32'h0, 32'h0,
                                         32'h0};
    bit          dir_ovf  [DIR_ROWS] = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0};
    bit          dir_dz   [DIR_ROWS] = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    postfix_stack_evaluator #(
        .STACK_DEPTH(EVAL_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic bit is_op(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void eval_push(input logic [31:0] v);
        if (eval_depth < EVAL_DEPTH) begin
            eval_stack[eval_depth] = v;
            eval_depth++;
        end else begin
            eval_ovf = 1'b1;
        end
    endfunction

    function automatic logic [31:0] eval_pop();
        if (eval_depth == 0)
            return EMPTY_VALUE;
        eval_depth--;
        return eval_stack[eval_depth];
    endfunction

    function automatic logic [31:0] eval_quotient(input logic [31:0] l, input logic [31:0] r);
        logic [31:0] ml, mr, q;
        if (r == 32'h0) begin
            eval_dz = 1'b1;
            return 32'h0;
        end
        ml = l[31] ? -l : l;
        mr = r[31] ? -r : r;
        q  = ml / mr;
        return (l[31] ^ r[31]) ? -q : q;
    endfunction

    function automatic void eval_step(input logic cmd, input logic [7:0] c,
                                      output bit emit, output expr_result_t res);
        logic [31:0] r, l, v;
        emit = 1'b0;
        res  = '0;
        if (cmd) begin
            res.value  = eval_pop();
            res.ovf    = eval_ovf;
            res.dz     = eval_dz;
            eval_depth = 0;
            eval_ovf   = 1'b0;
            eval_dz    = 1'b0;
            emit       = 1'b1;
        end else if (is_digit(c)) begin
            eval_push(32'(c - CH_ZERO));
        end else if (is_op(c)) begin
            r = eval_pop();
            l = eval_pop();
            case (c)
                CH_PLUS:  v = l + r;
                CH_MINUS: v = l - r;
                CH_STAR:  v = l * r;
                default:  v = eval_quotient(l, r);
            endcase
            eval_push(v);
        end
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] any_op();
        op_t op;
        op = op_t'($urandom_range(3));
        case (op)
            OP_ADD:  return CH_PLUS;
            OP_SUB:  return CH_MINUS;
            OP_MUL:  return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] any_ignored();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (is_digit(c) || is_op(c));
        return c;
    endfunction

    task automatic put_item(input logic cmd, input logic [7:0] c,
                            input bit use_fixed, input expr_result_t fixed);
        bit           emit;
        expr_result_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= c;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        if (cmd || is_digit(c) || is_op(c))
            live_items++;
        eval_step(cmd, c, emit, res);
        if (emit)
            awaited_results.push_back(use_fixed ? fixed : res);
    endtask

    task automatic run_expression();
        int kind, n, depth;
        kind = $urandom_range(99);
        if (kind < 70) begin
            n     = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            depth = 0;
            while (n > 0 || depth > 1) begin
                if ($urandom_range(19) == 0)
                    put_item(1'b0, any_ignored(), 1'b0, '0);
                if (n > 0 && (depth < 2 || $urandom_range(1) == 0)) begin
                    put_item(1'b0, any_digit(), 1'b0, '0);
                    n--;
                    depth++;
                end else begin
                    put_item(1'b0, any_op(), 1'b0, '0);
                    depth--;
                end
            end
        end else if (kind < 85) begin
            repeat ($urandom_range(1, 10))
                put_item(1'b0, $urandom_range(1) ? any_digit() : any_op(), 1'b0, '0);
        end else if (kind < 95) begin
            repeat ($urandom_range(1, 6))
                put_item(1'b0, 8'($urandom_range(255)), 1'b0, '0);
        end else if (kind >= 98) begin
            repeat ($urandom_range(EVAL_DEPTH - 3, EVAL_DEPTH + 3))
                put_item(1'b0, any_digit(), 1'b0, '0);
            repeat ($urandom_range(0, 3))
                put_item(1'b0, any_op(), 1'b0, '0);
        end
        put_item(1'b1, 8'($urandom_range(255)), 1'b0, '0);
    endtask

    // Check each result transfer and watch for a hang; sample away from the driving edge.
    always @(negedge aclk) begin
        expr_result_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual value %0d tuser %b",
                             $time, $signed(m_tdata), m_tuser);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata !== want.value) begin
                        $display("%0t value: expected %0d, actual %0d",
                                 $time, $signed(want.value), $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.ovf) begin
                        $display("%0t overflowed: expected %b, actual %b",
                                 $time, want.ovf, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.dz) begin
                        $display("%0t div_zero: expected %b, actual %b",
                                 $time, want.dz, m_tuser[1]);
                        fail_count++;
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL postfix_stack_evaluator");
                $finish;
            end
        end
    end

    initial begin
        expr_result_t fixed;
        int           rand_base, done;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            repeat (dir_nul[r])
                put_item(1'b0, 8'h00, 1'b0, '0);
            for (int k = 0; k < dir_reps[r]; k++)
                for (int c = 0; c < dir_text[r].len(); c++)
                    put_item(1'b0, dir_text[r][c], 1'b0, '0);
            fixed.value = dir_val[r];
            fixed.ovf   = dir_ovf[r];
            fixed.dz    = dir_dz[r];
            put_item(1'b1, 8'($urandom_range(255)), dir_chk[r], fixed);
        end

        // Sweep the idle pattern: sender light / receiver heavy, swapped, then none.
        rand_base = live_items;
        done      = 0;
        while (done < RAND_ITEMS) begin
            if (done < RAND_ITEMS / 3) begin
                src_idle_pct   = 20;
                sink_stall_pct = 67;
            end else if (done < 2 * RAND_ITEMS / 3) begin
                src_idle_pct   = 67;
                sink_stall_pct = 20;
            end else begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            run_expression();
            done = live_items - rand_base;
        end
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS postfix_stack_evaluator");
        else
            $display("FAIL postfix_stack_evaluator");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/pse_pkg.sv
rtl/pse_ram.sv
rtl/postfix_stack_evaluator.sv
rtl/pse_checker.sv
tb/postfix_stack_evaluator_tb.sv
